// File: sv/lsik_pkg.sv
// ----------------------------------------------------------------------------
// lsik_pkg
// Shared types, codes and constants of the two-link leg solver.
// ----------------------------------------------------------------------------
package lsik_pkg;

    localparam int CORDIC_ITERATIONS = 16;
    localparam int CORDIC_STEPS      = (CORDIC_ITERATIONS < 24) ? CORDIC_ITERATIONS : 24;
    localparam int CNT_W             = 5;

    localparam logic [CNT_W-1:0] DIV_LAST    = CNT_W'(15);
    localparam logic [CNT_W-1:0] SQRT_LAST   = CNT_W'(16);
    localparam logic [CNT_W-1:0] CORDIC_LAST = CNT_W'(CORDIC_STEPS - 1);

    localparam logic [2:0] REG_UPPER_LENGTH   = 3'd0;
    localparam logic [2:0] REG_LOWER_LENGTH   = 3'd1;
    localparam logic [2:0] REG_KNEE_FLIP      = 3'd2;
    localparam logic [2:0] REG_PHASE_RATE     = 3'd3;
    localparam logic [2:0] REG_FOLD_THRESHOLD = 3'd4;

    typedef enum logic [4:0] {
        ST_IDLE, ST_PHASE, ST_STEPX, ST_STEPY, ST_FOOTY, ST_DIFF,
        ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5,
        ST_SAT, ST_DIV, ST_CFIN, ST_CC, ST_SQINIT, ST_SQ, ST_SFIN,
        ST_ALOAD, ST_ANORM, ST_AROT, ST_AITER, ST_AFIN,
        ST_P0, ST_P1, ST_P2, ST_OUT
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_PHASE, OP_MUL_X, OP_FOOT_X, OP_FOOT_Y, OP_DIFF,
        OP_SQ_DX, OP_SQ_DY, OP_SQ_L1, OP_SQ_L2, OP_L1L2, OP_DEN,
        OP_SAT, OP_DIV, OP_CFIN, OP_CC, OP_SQINIT, OP_SQ, OP_SFIN,
        OP_ALOAD, OP_ANORM, OP_AROT, OP_AITER, OP_AFIN,
        OP_P0, OP_P1, OP_P2, OP_OUT
    } op_t;

    typedef enum logic [1:0] {
        SEL_KNEE, SEL_FOOT, SEL_LINK
    } sel_t;

    typedef struct packed {
        op_t              op;
        logic [CNT_W-1:0] cnt;
        sel_t             sel;
    } cmd_t;

    typedef struct packed {
        logic norm_done;
    } status_t;

    function automatic logic [23:0] atan_entry(input logic [CNT_W-1:0] idx);
        logic [23:0] v;
        case (idx)
            5'd0:    v = 24'd13176795;
            5'd1:    v = 24'd7778716;
            5'd2:    v = 24'd4110060;
            5'd3:    v = 24'd2086331;
            5'd4:    v = 24'd1047214;
            5'd5:    v = 24'd524117;
            5'd6:    v = 24'd262123;
            5'd7:    v = 24'd131069;
            5'd8:    v = 24'd65536;
            5'd9:    v = 24'd32768;
            5'd10:   v = 24'd16384;
            5'd11:   v = 24'd8192;
            5'd12:   v = 24'd4096;
            5'd13:   v = 24'd2048;
            5'd14:   v = 24'd1024;
            5'd15:   v = 24'd512;
            5'd16:   v = 24'd256;
            5'd17:   v = 24'd128;
            5'd18:   v = 24'd64;
            5'd19:   v = 24'd32;
            5'd20:   v = 24'd16;
            5'd21:   v = 24'd8;
            5'd22:   v = 24'd4;
            5'd23:   v = 24'd2;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

endpackage

// File: sv/leg_step_two_link_ik_unit.sv
// ----------------------------------------------------------------------------
// leg_step_two_link_ik_unit
// Stepping foot and two-link planar inverse kinematics, one result per tick.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel carries one tick per transaction: hip and target position.
//   Master channel returns hip and knee angles, foot position and the step
//   flag for that tick. Link lengths, knee flip, phase rate and fold
//   threshold are written on the cfg port while the unit is idle.
//   One tick is taken at a time. From acceptance to m_tvalid the tick runs
//   through the shared 26x26 multiplier sequence, a 16-step restoring
//   divider, a 17-step square root and three passes through one CORDIC
//   unit (16 iterations each, after a normalising shift). The next tick is
//   taken as soon as the sequence ends, while the previous result may
//   still be held in the output register.
//   If the receiver stalls, the result is held and the sequence waits at its
//   last step until the output register is free.
//   Reset clears the foot, step state and last knee angle and loads the
//   default register values; the unit is ready on the next cycle.
// ----------------------------------------------------------------------------
module leg_step_two_link_ik_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [21:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // hip_x, hip_y, target_x, target_y
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // hip_angle, knee_angle, foot_x, foot_y, zero pad
    output logic [0:0]  m_tuser    // in_step
);

    lsik_pkg::cmd_t     cmd;
    lsik_pkg::status_t  status;
    logic signed [16:0] hip_angle;
    logic signed [15:0] knee_angle;
    logic signed [23:0] foot_x, foot_y;
    logic               in_step;

    lsik_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lsik_dpath u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .hip_x      (s_tdata[23:0]),
        .hip_y      (s_tdata[47:24]),
        .target_x   (s_tdata[71:48]),
        .target_y   (s_tdata[95:72]),
        .cmd        (cmd),
        .status     (status),
        .hip_angle  (hip_angle),
        .knee_angle (knee_angle),
        .foot_x     (foot_x),
        .foot_y     (foot_y),
        .in_step    (in_step)
    );

    assign m_tdata = {7'b0, foot_y, foot_x, knee_angle, hip_angle};
    assign m_tuser = in_step;

endmodule

// File: sv/lsik_ctrl.sv
// ----------------------------------------------------------------------------
// lsik_ctrl
// Sequencer: steps the datapath through step update, divide, root and CORDIC.
// ----------------------------------------------------------------------------
module lsik_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  lsik_pkg::status_t  status,
    output lsik_pkg::cmd_t     cmd
);

    lsik_pkg::state_t              state_reg, state_next;
    logic [lsik_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    lsik_pkg::sel_t                sel_reg, sel_next;
    logic                          m_valid_reg, m_valid_next;
    logic                          out_free;

    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lsik_pkg::ST_IDLE;
            cnt_reg     <= '0;
            sel_reg     <= lsik_pkg::SEL_KNEE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            sel_reg     <= sel_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        sel_next     = sel_reg;
        m_valid_next = m_valid_reg && !m_tready;
        unique case (state_reg)
            lsik_pkg::ST_IDLE:   if (s_tvalid) state_next = lsik_pkg::ST_PHASE;
            lsik_pkg::ST_PHASE:  state_next = lsik_pkg::ST_STEPX;
            lsik_pkg::ST_STEPX:  state_next = lsik_pkg::ST_STEPY;
            lsik_pkg::ST_STEPY:  state_next = lsik_pkg::ST_FOOTY;
            lsik_pkg::ST_FOOTY:  state_next = lsik_pkg::ST_DIFF;
            lsik_pkg::ST_DIFF:   state_next = lsik_pkg::ST_M0;
            lsik_pkg::ST_M0:     state_next = lsik_pkg::ST_M1;
            lsik_pkg::ST_M1:     state_next = lsik_pkg::ST_M2;
            lsik_pkg::ST_M2:     state_next = lsik_pkg::ST_M3;
            lsik_pkg::ST_M3:     state_next = lsik_pkg::ST_M4;
            lsik_pkg::ST_M4:     state_next = lsik_pkg::ST_M5;
            lsik_pkg::ST_M5:     state_next = lsik_pkg::ST_SAT;
            lsik_pkg::ST_SAT: begin
                state_next = lsik_pkg::ST_DIV;
                cnt_next   = '0;
            end
            lsik_pkg::ST_DIV: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == lsik_pkg::DIV_LAST) state_next = lsik_pkg::ST_CFIN;
            end
            lsik_pkg::ST_CFIN:   state_next = lsik_pkg::ST_CC;
            lsik_pkg::ST_CC:     state_next = lsik_pkg::ST_SQINIT;
            lsik_pkg::ST_SQINIT: begin
                state_next = lsik_pkg::ST_SQ;
                cnt_next   = '0;
            end
            lsik_pkg::ST_SQ: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == lsik_pkg::SQRT_LAST) state_next = lsik_pkg::ST_SFIN;
            end
            lsik_pkg::ST_SFIN: begin
                state_next = lsik_pkg::ST_ALOAD;
                sel_next   = lsik_pkg::SEL_KNEE;
            end
            lsik_pkg::ST_ALOAD:  state_next = lsik_pkg::ST_ANORM;
            lsik_pkg::ST_ANORM:  if (status.norm_done) state_next = lsik_pkg::ST_AROT;
            lsik_pkg::ST_AROT: begin
                state_next = lsik_pkg::ST_AITER;
                cnt_next   = '0;
            end
            lsik_pkg::ST_AITER: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == lsik_pkg::CORDIC_LAST) state_next = lsik_pkg::ST_AFIN;
            end
            lsik_pkg::ST_AFIN: begin
                unique case (sel_reg)
                    lsik_pkg::SEL_KNEE: state_next = lsik_pkg::ST_P0;
                    lsik_pkg::SEL_FOOT: begin
                        state_next = lsik_pkg::ST_ALOAD;
                        sel_next   = lsik_pkg::SEL_LINK;
                    end
                    default:            state_next = lsik_pkg::ST_OUT;
                endcase
            end
            lsik_pkg::ST_P0:     state_next = lsik_pkg::ST_P1;
            lsik_pkg::ST_P1:     state_next = lsik_pkg::ST_P2;
            lsik_pkg::ST_P2: begin
                state_next = lsik_pkg::ST_ALOAD;
                sel_next   = lsik_pkg::SEL_FOOT;
            end
            lsik_pkg::ST_OUT: begin
                if (out_free) begin
                    state_next   = lsik_pkg::ST_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default:             state_next = lsik_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd.cnt = cnt_reg;
        cmd.sel = sel_reg;
        unique case (state_reg)
            lsik_pkg::ST_IDLE:   cmd.op = s_tvalid ? lsik_pkg::OP_LOAD : lsik_pkg::OP_NONE;
            lsik_pkg::ST_PHASE:  cmd.op = lsik_pkg::OP_PHASE;
            lsik_pkg::ST_STEPX:  cmd.op = lsik_pkg::OP_MUL_X;
            lsik_pkg::ST_STEPY:  cmd.op = lsik_pkg::OP_FOOT_X;
            lsik_pkg::ST_FOOTY:  cmd.op = lsik_pkg::OP_FOOT_Y;
            lsik_pkg::ST_DIFF:   cmd.op = lsik_pkg::OP_DIFF;
            lsik_pkg::ST_M0:     cmd.op = lsik_pkg::OP_SQ_DX;
            lsik_pkg::ST_M1:     cmd.op = lsik_pkg::OP_SQ_DY;
            lsik_pkg::ST_M2:     cmd.op = lsik_pkg::OP_SQ_L1;
            lsik_pkg::ST_M3:     cmd.op = lsik_pkg::OP_SQ_L2;
            lsik_pkg::ST_M4:     cmd.op = lsik_pkg::OP_L1L2;
            lsik_pkg::ST_M5:     cmd.op = lsik_pkg::OP_DEN;
            lsik_pkg::ST_SAT:    cmd.op = lsik_pkg::OP_SAT;
            lsik_pkg::ST_DIV:    cmd.op = lsik_pkg::OP_DIV;
            lsik_pkg::ST_CFIN:   cmd.op = lsik_pkg::OP_CFIN;
            lsik_pkg::ST_CC:     cmd.op = lsik_pkg::OP_CC;
            lsik_pkg::ST_SQINIT: cmd.op = lsik_pkg::OP_SQINIT;
            lsik_pkg::ST_SQ:     cmd.op = lsik_pkg::OP_SQ;
            lsik_pkg::ST_SFIN:   cmd.op = lsik_pkg::OP_SFIN;
            lsik_pkg::ST_ALOAD:  cmd.op = lsik_pkg::OP_ALOAD;
            lsik_pkg::ST_ANORM:  cmd.op = lsik_pkg::OP_ANORM;
            lsik_pkg::ST_AROT:   cmd.op = lsik_pkg::OP_AROT;
            lsik_pkg::ST_AITER:  cmd.op = lsik_pkg::OP_AITER;
            lsik_pkg::ST_AFIN:   cmd.op = lsik_pkg::OP_AFIN;
            lsik_pkg::ST_P0:     cmd.op = lsik_pkg::OP_P0;
            lsik_pkg::ST_P1:     cmd.op = lsik_pkg::OP_P1;
            lsik_pkg::ST_P2:     cmd.op = lsik_pkg::OP_P2;
            lsik_pkg::ST_OUT:    cmd.op = out_free ? lsik_pkg::OP_OUT : lsik_pkg::OP_NONE;
            default:             cmd.op = lsik_pkg::OP_NONE;
        endcase
    end

    assign s_tready = (state_reg == lsik_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;

`ifndef SYNTHESIS
    a_out_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == lsik_pkg::OP_OUT) |=> m_tvalid)
        else $error("result load did not raise m_tvalid");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> (cmd.op != lsik_pkg::OP_OUT))
        else $error("pending result overwritten");
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == lsik_pkg::ST_PHASE))
        else $error("accepted transaction did not start the sequence");
    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lsik_pkg::ST_DIV) |-> (cnt_reg <= lsik_pkg::DIV_LAST))
        else $error("divider count out of range");
`endif

endmodule

// File: sv/lsik_dpath.sv
// ----------------------------------------------------------------------------
// lsik_dpath
// Datapath: state, shared multiplier, divider, square root and CORDIC unit.
// ----------------------------------------------------------------------------
module lsik_dpath (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [2:0]          cfg_index,
    input  logic [21:0]         cfg_wdata,
    input  logic signed [23:0]  hip_x,
    input  logic signed [23:0]  hip_y,
    input  logic signed [23:0]  target_x,
    input  logic signed [23:0]  target_y,
    input  lsik_pkg::cmd_t      cmd,
    output lsik_pkg::status_t   status,
    output logic signed [16:0]  hip_angle,
    output logic signed [15:0]  knee_angle,
    output logic signed [23:0]  foot_x,
    output logic signed [23:0]  foot_y,
    output logic                in_step
);

    localparam int MW    = 26;
    localparam int PW    = 52;
    localparam int ACC_W = 51;
    localparam int DEN_W = 46;
    localparam int REM_W = 47;
    localparam int CW    = 46;
    localparam int ZW    = 28;

    localparam logic signed [CW-1:0] NORM_HI  = 46'sh100_0000_0000;
    localparam logic signed [CW-1:0] NORM_MID = 46'sh010_0000_0000;
    localparam logic signed [ZW-1:0] HALF_PI  = 28'sd26353589;
    localparam logic signed [ZW-1:0] ANG_MAX  = 28'sd25736;

    logic [21:0]          upper_len_reg, lower_len_reg;
    logic                 flip_reg;
    logic [15:0]          rate_reg;
    logic [14:0]          fold_reg;

    logic signed [23:0]   hx_reg, hy_reg, tx_reg, ty_reg;
    logic signed [23:0]   foot_x_reg, foot_y_reg, start_x_reg, start_y_reg;
    logic [16:0]          phase_reg;
    logic                 active_reg, moving_reg;
    logic signed [15:0]   last_knee_reg;

    logic signed [24:0]   dx_reg, dy_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [DEN_W-1:0]     den_reg;
    logic                 sat_pos_reg, sat_neg_reg, neg_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [15:0]          quo_reg;
    logic signed [17:0]   c_reg, s_reg;
    logic [32:0]          sv_reg;
    logic [33:0]          sr_reg;
    logic signed [CW-1:0] cx_reg, cy_reg;
    logic signed [ZW-1:0] cz_reg;
    logic                 zero_reg;
    logic signed [41:0]   aux_x_reg, aux_y_reg;
    logic signed [15:0]   knee_reg, ang1_reg, ang2_reg;

    logic signed [16:0]   hip_out_reg;
    logic signed [15:0]   knee_out_reg;
    logic signed [23:0]   fx_out_reg, fy_out_reg;
    logic                 step_out_reg;

    // shared multiplier
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] mul_p;
    logic signed [24:0]   diff_x, diff_y;

    assign diff_x = $signed({tx_reg[23], tx_reg}) - $signed({start_x_reg[23], start_x_reg});
    assign diff_y = $signed({ty_reg[23], ty_reg}) - $signed({start_y_reg[23], start_y_reg});

    always_comb begin
        unique case (cmd.op)
            lsik_pkg::OP_MUL_X: begin
                mul_a = {diff_x[24], diff_x};
                mul_b = $signed({9'b0, phase_reg});
            end
            lsik_pkg::OP_FOOT_X: begin
                mul_a = {diff_y[24], diff_y};
                mul_b = $signed({9'b0, phase_reg});
            end
            lsik_pkg::OP_SQ_DX: begin
                mul_a = {dx_reg[24], dx_reg};
                mul_b = {dx_reg[24], dx_reg};
            end
            lsik_pkg::OP_SQ_DY: begin
                mul_a = {dy_reg[24], dy_reg};
                mul_b = {dy_reg[24], dy_reg};
            end
            lsik_pkg::OP_SQ_L1: begin
                mul_a = $signed({4'b0, upper_len_reg});
                mul_b = $signed({4'b0, upper_len_reg});
            end
            lsik_pkg::OP_SQ_L2: begin
                mul_a = $signed({4'b0, lower_len_reg});
                mul_b = $signed({4'b0, lower_len_reg});
            end
            lsik_pkg::OP_L1L2: begin
                mul_a = $signed({4'b0, upper_len_reg});
                mul_b = $signed({4'b0, lower_len_reg});
            end
            lsik_pkg::OP_CC: begin
                mul_a = {{8{c_reg[17]}}, c_reg};
                mul_b = {{8{c_reg[17]}}, c_reg};
            end
            lsik_pkg::OP_P0: begin
                mul_a = $signed({4'b0, lower_len_reg});
                mul_b = {{8{s_reg[17]}}, s_reg};
            end
            lsik_pkg::OP_P1: begin
                mul_a = $signed({4'b0, lower_len_reg});
                mul_b = {{8{c_reg[17]}}, c_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // step interpolation
    logic [16:0]          phase_sum;
    logic [16:0]          knee_mag;
    logic signed [PW-1:0] foot_rnd, foot_sum;
    logic signed [23:0]   foot_base, foot_sat;

    assign phase_sum = phase_reg + {1'b0, rate_reg};
    assign knee_mag  = last_knee_reg[15] ? 17'(-$signed({last_knee_reg[15], last_knee_reg}))
                                         : {1'b0, last_knee_reg};
    assign foot_base = (cmd.op == lsik_pkg::OP_FOOT_X) ? start_x_reg : start_y_reg;
    assign foot_rnd  = prod_reg + PW'(32768);
    assign foot_sum  = (foot_rnd >>> 16) + $signed({{(PW-24){foot_base[23]}}, foot_base});

    always_comb begin
        if (foot_sum > $signed(PW'(8388607))) begin
            foot_sat = 24'sh7FFFFF;
        end else if (foot_sum < -$signed(PW'(8388608))) begin
            foot_sat = 24'sh800000;
        end else begin
            foot_sat = foot_sum[23:0];
        end
    end

    // divider and root
    logic signed [ACC_W-1:0] den_s, acc_mag;
    logic [REM_W-1:0]        rem_dbl;
    logic                    rem_ge;
    logic [5:0]              sq_sh;
    logic [33:0]             sq_bit, sq_t;
    logic                    sq_ge;

    assign den_s   = $signed({5'b0, den_reg});
    assign acc_mag = acc_reg[ACC_W-1] ? -acc_reg : acc_reg;
    assign rem_dbl = {rem_reg[REM_W-2:0], 1'b0};
    assign rem_ge  = rem_dbl >= {1'b0, den_reg};
    assign sq_sh   = 6'd32 - {cmd.cnt, 1'b0};
    assign sq_bit  = 34'd1 << sq_sh;
    assign sq_t    = sr_reg + sq_bit;
    assign sq_ge   = {1'b0, sv_reg} >= sq_t;

    // cordic
    logic signed [CW-1:0] xs, ys, load_x, load_y;
    logic signed [ZW-1:0] atan_z, z_rnd;
    logic signed [15:0]   ang;
    logic                 small_hi, small_mid;

    assign xs     = cx_reg >>> cmd.cnt;
    assign ys     = cy_reg >>> cmd.cnt;
    assign atan_z = $signed({4'b0, lsik_pkg::atan_entry(cmd.cnt)});
    assign z_rnd  = (cz_reg + ZW'(1024)) >>> 11;

    assign small_hi  = (cx_reg < NORM_HI) && (cx_reg > -NORM_HI)
                    && (cy_reg < NORM_HI) && (cy_reg > -NORM_HI);
    assign small_mid = (cx_reg < NORM_MID) && (cx_reg > -NORM_MID)
                    && (cy_reg < NORM_MID) && (cy_reg > -NORM_MID);
    assign status.norm_done = zero_reg || !small_hi;

    always_comb begin
        if (zero_reg) begin
            ang = '0;
        end else if (z_rnd > ANG_MAX) begin
            ang = 16'(ANG_MAX);
        end else if (z_rnd < -ANG_MAX) begin
            ang = 16'(-ANG_MAX);
        end else begin
            ang = z_rnd[15:0];
        end
    end

    always_comb begin
        unique case (cmd.sel)
            lsik_pkg::SEL_KNEE: begin
                load_x = {{(CW-18){c_reg[17]}}, c_reg};
                load_y = {{(CW-18){s_reg[17]}}, s_reg};
            end
            lsik_pkg::SEL_FOOT: begin
                load_x = {{(CW-25){dx_reg[24]}}, dx_reg};
                load_y = {{(CW-25){dy_reg[24]}}, dy_reg};
            end
            default: begin
                load_x = {{(CW-42){aux_x_reg[41]}}, aux_x_reg};
                load_y = {{(CW-42){aux_y_reg[41]}}, aux_y_reg};
            end
        endcase
    end

    // configuration and leg state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upper_len_reg <= 22'd409600;
            lower_len_reg <= 22'd409600;
            flip_reg      <= 1'b0;
            rate_reg      <= 16'd3277;
            fold_reg      <= 15'd1229;
            foot_x_reg    <= '0;
            foot_y_reg    <= '0;
            start_x_reg   <= '0;
            start_y_reg   <= '0;
            phase_reg     <= '0;
            active_reg    <= 1'b0;
            last_knee_reg <= '0;
            moving_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    lsik_pkg::REG_UPPER_LENGTH:   upper_len_reg <= cfg_wdata;
                    lsik_pkg::REG_LOWER_LENGTH:   lower_len_reg <= cfg_wdata;
                    lsik_pkg::REG_KNEE_FLIP:      flip_reg      <= cfg_wdata[0];
                    lsik_pkg::REG_PHASE_RATE:     rate_reg      <= cfg_wdata[15:0];
                    lsik_pkg::REG_FOLD_THRESHOLD: fold_reg      <= cfg_wdata[14:0];
                    default: ;
                endcase
            end
            unique case (cmd.op)
                lsik_pkg::OP_PHASE: begin
                    moving_reg <= active_reg;
                    if (active_reg) begin
                        phase_reg <= phase_sum;
                        if (phase_sum > 17'd65536) active_reg <= 1'b0;
                    end else if (knee_mag < {2'b0, fold_reg}) begin
                        start_x_reg <= foot_x_reg;
                        start_y_reg <= foot_y_reg;
                        phase_reg   <= '0;
                        active_reg  <= 1'b1;
                    end
                end
                lsik_pkg::OP_FOOT_X: if (moving_reg) foot_x_reg <= foot_sat;
                lsik_pkg::OP_FOOT_Y: if (moving_reg) foot_y_reg <= foot_sat;
                lsik_pkg::OP_AFIN: begin
                    if (cmd.sel == lsik_pkg::SEL_KNEE) begin
                        last_knee_reg <= flip_reg ? -ang : ang;
                    end
                end
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            lsik_pkg::OP_LOAD: begin
                hx_reg <= hip_x;
                hy_reg <= hip_y;
                tx_reg <= target_x;
                ty_reg <= target_y;
            end
            lsik_pkg::OP_MUL_X:  prod_reg <= mul_p;
            lsik_pkg::OP_FOOT_X: prod_reg <= mul_p;
            lsik_pkg::OP_DIFF: begin
                dx_reg <= $signed({foot_x_reg[23], foot_x_reg}) - $signed({hx_reg[23], hx_reg});
                dy_reg <= $signed({foot_y_reg[23], foot_y_reg}) - $signed({hy_reg[23], hy_reg});
            end
            lsik_pkg::OP_SQ_DX:  prod_reg <= mul_p;
            lsik_pkg::OP_SQ_DY: begin
                acc_reg  <= prod_reg[ACC_W-1:0];
                prod_reg <= mul_p;
            end
            lsik_pkg::OP_SQ_L1: begin
                acc_reg  <= acc_reg + prod_reg[ACC_W-1:0];
                prod_reg <= mul_p;
            end
            lsik_pkg::OP_SQ_L2: begin
                acc_reg  <= acc_reg - prod_reg[ACC_W-1:0];
                prod_reg <= mul_p;
            end
            lsik_pkg::OP_L1L2: begin
                acc_reg  <= acc_reg - prod_reg[ACC_W-1:0];
                prod_reg <= mul_p;
            end
            lsik_pkg::OP_DEN:    den_reg <= {prod_reg[DEN_W-2:0], 1'b0};
            lsik_pkg::OP_SAT: begin
                sat_pos_reg <= acc_reg >= den_s;
                sat_neg_reg <= acc_reg <= -den_s;
                neg_reg     <= acc_reg[ACC_W-1];
                rem_reg     <= acc_mag[REM_W-1:0];
                quo_reg     <= '0;
            end
            lsik_pkg::OP_DIV: begin
                rem_reg <= rem_ge ? (rem_dbl - {1'b0, den_reg}) : rem_dbl;
                quo_reg <= {quo_reg[14:0], rem_ge};
            end
            lsik_pkg::OP_CFIN: begin
                priority if (sat_pos_reg) begin
                    c_reg <= 18'sd65536;
                end else if (sat_neg_reg) begin
                    c_reg <= -18'sd65536;
                end else if (neg_reg) begin
                    c_reg <= -$signed({2'b0, quo_reg});
                end else begin
                    c_reg <= $signed({2'b0, quo_reg});
                end
            end
            lsik_pkg::OP_CC:     prod_reg <= mul_p;
            lsik_pkg::OP_SQINIT: begin
                sv_reg <= 33'h1_0000_0000 - prod_reg[32:0];
                sr_reg <= '0;
            end
            lsik_pkg::OP_SQ: begin
                if (sq_ge) begin
                    sv_reg <= sv_reg - sq_t[32:0];
                    sr_reg <= (sr_reg >> 1) + sq_bit;
                end else begin
                    sr_reg <= sr_reg >> 1;
                end
            end
            lsik_pkg::OP_SFIN:   s_reg <= $signed(sr_reg[17:0]);
            lsik_pkg::OP_ALOAD: begin
                cx_reg   <= load_x;
                cy_reg   <= load_y;
                cz_reg   <= '0;
                zero_reg <= (load_x == '0) && (load_y == '0);
            end
            lsik_pkg::OP_ANORM: begin
                if (!zero_reg && small_hi) begin
                    if (small_mid) begin
                        cx_reg <= cx_reg <<< 4;
                        cy_reg <= cy_reg <<< 4;
                    end else begin
                        cx_reg <= cx_reg <<< 1;
                        cy_reg <= cy_reg <<< 1;
                    end
                end
            end
            lsik_pkg::OP_AROT: begin
                if (cx_reg[CW-1]) begin
                    if (!cy_reg[CW-1]) begin
                        cz_reg <= HALF_PI;
                        cx_reg <= cy_reg;
                        cy_reg <= -cx_reg;
                    end else begin
                        cz_reg <= -HALF_PI;
                        cx_reg <= -cy_reg;
                        cy_reg <= cx_reg;
                    end
                end
            end
            lsik_pkg::OP_AITER: begin
                if (!cy_reg[CW-1]) begin
                    cx_reg <= cx_reg + ys;
                    cy_reg <= cy_reg - xs;
                    cz_reg <= cz_reg + atan_z;
                end else begin
                    cx_reg <= cx_reg - ys;
                    cy_reg <= cy_reg + xs;
                    cz_reg <= cz_reg - atan_z;
                end
            end
            lsik_pkg::OP_AFIN: begin
                unique case (cmd.sel)
                    lsik_pkg::SEL_KNEE: begin
                        knee_reg <= flip_reg ? -ang : ang;
                        if (flip_reg) s_reg <= -s_reg;
                    end
                    lsik_pkg::SEL_FOOT: ang1_reg <= ang;
                    default:            ang2_reg <= ang;
                endcase
            end
            lsik_pkg::OP_P0:     prod_reg <= mul_p;
            lsik_pkg::OP_P1: begin
                aux_y_reg <= prod_reg[41:0];
                prod_reg  <= mul_p;
            end
            lsik_pkg::OP_P2: begin
                aux_x_reg <= $signed({4'b0, upper_len_reg, 16'b0}) + prod_reg[41:0];
            end
            lsik_pkg::OP_OUT: begin
                hip_out_reg  <= $signed({ang1_reg[15], ang1_reg}) - $signed({ang2_reg[15], ang2_reg});
                knee_out_reg <= knee_reg;
                fx_out_reg   <= foot_x_reg;
                fy_out_reg   <= foot_y_reg;
                step_out_reg <= active_reg;
            end
            default: ;
        endcase
    end

    assign hip_angle  = hip_out_reg;
    assign knee_angle = knee_out_reg;
    assign foot_x     = fx_out_reg;
    assign foot_y     = fy_out_reg;
    assign in_step    = step_out_reg;

endmodule

// File: sim/leg_step_two_link_ik_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// leg_step_two_link_ik_unit_tb
// Self-checking bench for the stepping leg solver: a queue-fed driver offers
// hip and target ticks, a behavioural predictor of the foot stepping and the
// inverse kinematics computes each result, and a monitor compares every
// returned transaction field by field across several register settings.
// ----------------------------------------------------------------------------
module leg_step_two_link_ik_unit_tb;

    typedef struct packed {
        logic signed [23:0] target_y;
        logic signed [23:0] target_x;
        logic signed [23:0] hip_y;
        logic signed [23:0] hip_x;
    } tick_t;

    typedef struct {
        logic signed [16:0] hip_angle;
        logic signed [15:0] knee_angle;
        logic signed [23:0] foot_x;
        logic signed [23:0] foot_y;
        logic               in_step;
    } pose_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [21:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;   // hip_x, hip_y, target_x, target_y
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;   // hip_angle, knee_angle, foot_x, foot_y, zero pad
    logic [0:0]  m_tuser;   // in_step

    leg_step_two_link_ik_unit dut (.*);

    // predictor copy of registers and state
    longint len_upper, len_lower, flip, rate, fold;
    longint foot_px, foot_py, start_px, start_py, phase, last_knee;
    bit     stepping;

    tick_t  tick_q[$];
    pose_t  pose_q[$];
    int     errors;
    int     hold_off;
    int     gap;
    bit     driver_pause;

    localparam longint ATAN_Z[24] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2};

    function automatic longint asr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint clamp24(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    function automatic longint root_floor(longint v);
        longint r, b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic longint angle_of(longint y, longint x);
        longint z, t, xs, ys, r;
        z = 0;
        if (x == 0 && y == 0) return 0;
        while (mag(x) < (64'sd1 <<< 40) && mag(y) < (64'sd1 <<< 40)) begin
            x = x * 2;
            y = y * 2;
        end
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                z = 26353589; x = y; y = -t;
            end else begin
                z = -26353589; x = -y; y = t;
            end
        end
        for (int i = 0; i < lsik_pkg::CORDIC_STEPS; i++) begin
            xs = asr(x, i);
            ys = asr(y, i);
            if (y >= 0) begin
                x += ys; y -= xs; z += ATAN_Z[i];
            end else begin
                x -= ys; y += xs; z -= ATAN_Z[i];
            end
        end
        r = asr(z + 1024, 11);
        if (r > 25736) r = 25736;
        if (r < -25736) r = -25736;
        return r;
    endfunction

    function automatic pose_t solve_leg(tick_t t);
        pose_t  p;
        longint dx, dy, num, den, c, s, knee, hip;
        if (stepping) begin
            phase = (phase + rate) & 'h1FFFF;
            if (phase > 65536) stepping = 0;
            foot_px = clamp24(start_px + asr((longint'(t.target_x) - start_px) * phase + 32768, 16));
            foot_py = clamp24(start_py + asr((longint'(t.target_y) - start_py) * phase + 32768, 16));
        end else if (mag(last_knee) < fold) begin
            start_px = foot_px;
            start_py = foot_py;
            phase = 0;
            stepping = 1;
        end
        dx = foot_px - longint'(t.hip_x);
        dy = foot_py - longint'(t.hip_y);
        num = dx * dx + dy * dy - len_upper * len_upper - len_lower * len_lower;
        den = 2 * len_upper * len_lower;
        if (den == 0) c = num < 0 ? -65536 : 65536;
        else if (num >= den) c = 65536;
        else if (num <= -den) c = -65536;
        else if (num < 0) c = -((-num) * 65536 / den);
        else c = num * 65536 / den;
        s = root_floor(64'sd4294967296 - c * c);
        knee = angle_of(s, c);
        if (flip != 0) begin
            knee = -knee;
            s = -s;
        end
        hip = angle_of(dy, dx) - angle_of(len_lower * s, len_upper * 65536 + len_lower * c);
        last_knee = knee;
        p.hip_angle = hip[16:0];
        p.knee_angle = knee[15:0];
        p.foot_x = foot_px[23:0];
        p.foot_y = foot_py[23:0];
        p.in_step = stepping;
        return p;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 0;
            gap <= 0;
        end else if (s_tvalid && !s_tready) begin
        end else begin
            if (s_tvalid) begin
                pose_q.push_back(solve_leg(tick_t'(s_tdata)));
                void'(tick_q.pop_front());
            end
            if (gap > 0) begin
                gap <= gap - 1;
                s_tvalid <= 0;
            end else if (tick_q.size() > 0 && !driver_pause) begin
                if ($urandom_range(0, 7) == 0) begin
                    gap <= $urandom_range(0, 9) == 0 ? $urandom_range(100, 600)
                                                     : $urandom_range(1, 3);
                    s_tvalid <= 0;
                end else begin
                    s_tvalid <= 1;
                    s_tdata <= tick_q[0];
                end
            end else begin
                s_tvalid <= 0;
            end
        end
    end

    // receiver
    always @(posedge aclk) begin
        pose_t e;
        if (!aresetn) begin
            m_tready <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pose_q.size() == 0) begin
                    report("unexpected result", 0, 0);
                end else begin
                    e = pose_q.pop_front();
                    if ($signed(m_tdata[16:0]) != e.hip_angle)
                        report("hip_angle", $signed(m_tdata[16:0]), e.hip_angle);
                    if ($signed(m_tdata[32:17]) != e.knee_angle)
                        report("knee_angle", $signed(m_tdata[32:17]), e.knee_angle);
                    if ($signed(m_tdata[56:33]) != e.foot_x)
                        report("foot_x", $signed(m_tdata[56:33]), e.foot_x);
                    if ($signed(m_tdata[80:57]) != e.foot_y)
                        report("foot_y", $signed(m_tdata[80:57]), e.foot_y);
                    if (m_tuser[0] != e.in_step)
                        report("in_step", m_tuser[0], e.in_step);
                end
            end
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                m_tready <= 0;
            end else if ($urandom_range(0, 30) == 0) begin
                hold_off <= $urandom_range(0, 9) == 0 ? $urandom_range(50, 400) : $urandom_range(1, 4);
                m_tready <= 0;
            end else begin
                m_tready <= 1;
            end
        end
    end

    function automatic logic signed [23:0] rnd_coord(int kind);
        case (kind)
            0: return 24'($urandom);
            1: return $signed(24'($urandom_range(0, 2000000))) - 24'sd1000000;
            default: return $signed(24'($urandom_range(0, 200000))) - 24'sd100000;
        endcase
    endfunction

    function automatic tick_t rnd_tick();
        tick_t t;
        int k;
        k = $urandom_range(0, 9) == 0 ? 0 : ($urandom_range(0, 3) == 0 ? 1 : 2);
        t.hip_x = rnd_coord(k);
        t.hip_y = rnd_coord(k);
        t.target_x = rnd_coord(k);
        t.target_y = rnd_coord(k);
        return t;
    endfunction

    task automatic write_reg(logic [2:0] idx, longint v);
        @(posedge aclk);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_wdata <= v[21:0];
        @(posedge aclk);
        cfg_wr_en <= 0;
        case (idx)
            lsik_pkg::REG_UPPER_LENGTH:   len_upper = v & 'h3FFFFF;
            lsik_pkg::REG_LOWER_LENGTH:   len_lower = v & 'h3FFFFF;
            lsik_pkg::REG_KNEE_FLIP:      flip = v & 1;
            lsik_pkg::REG_PHASE_RATE:     rate = v & 'hFFFF;
            lsik_pkg::REG_FOLD_THRESHOLD: fold = v & 'h7FFF;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (tick_q.size() > 0 || s_tvalid || pose_q.size() > 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic load_ticks(int n);
        for (int i = 0; i < n; i++) tick_q.push_back(rnd_tick());
    endtask

    initial begin
        tick_t t;
        aresetn = 0;
        cfg_wr_en = 0;
        cfg_index = lsik_pkg::REG_UPPER_LENGTH;
        cfg_wdata = 0;
        s_tdata = 0;
        errors = 0;
        hold_off = 0;
        driver_pause = 0;
        len_upper = 409600; len_lower = 409600; flip = 0; rate = 3277; fold = 1229;
        foot_px = 0; foot_py = 0; start_px = 0; start_py = 0;
        phase = 0; last_knee = 0; stepping = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: extremes, zero vector, full reach and folded leg
        tick_q.push_back('0);
        t.hip_x = 24'sh7FFFFF; t.hip_y = 24'sh800000;
        t.target_x = 24'sh800000; t.target_y = 24'sh7FFFFF;
        tick_q.push_back(t);
        t.hip_x = 24'sh800000; t.hip_y = 24'sh7FFFFF;
        t.target_x = 24'sh7FFFFF; t.target_y = 24'sh800000;
        tick_q.push_back(t);
        for (int i = 0; i < 6; i++) begin
            t.hip_x = 0; t.hip_y = 24'(i * 150000);
            t.target_x = 24'(-i * 300000); t.target_y = 24'sh7FFFFF;
            tick_q.push_back(t);
        end
        drain();

        // zero link lengths, flipped knee, fast steps with overshoot
        write_reg(lsik_pkg::REG_UPPER_LENGTH, 0);
        write_reg(lsik_pkg::REG_LOWER_LENGTH, 0);
        write_reg(lsik_pkg::REG_KNEE_FLIP, 1);
        write_reg(lsik_pkg::REG_PHASE_RATE, 65535);
        write_reg(lsik_pkg::REG_FOLD_THRESHOLD, 25736);
        for (int i = 0; i < 6; i++) begin
            t.hip_x = 0; t.hip_y = 0;
            t.target_x = (i % 2) ? 24'sh7FFFFF : 24'sh800000;
            t.target_y = (i % 2) ? 24'sh800000 : 24'sh7FFFFF;
            tick_q.push_back(t);
        end
        drain();

        write_reg(lsik_pkg::REG_UPPER_LENGTH, 4194303);
        write_reg(lsik_pkg::REG_LOWER_LENGTH, 1);
        write_reg(lsik_pkg::REG_FOLD_THRESHOLD, 0);
        load_ticks(6);
        drain();

        // random phases over several settings
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(lsik_pkg::REG_UPPER_LENGTH, ph == 5 ? $urandom_range(0, 4194303)
                                                          : $urandom_range(100000, 600000));
            write_reg(lsik_pkg::REG_LOWER_LENGTH, ph == 5 ? $urandom_range(0, 4194303)
                                                          : $urandom_range(100000, 600000));
            write_reg(lsik_pkg::REG_KNEE_FLIP, ph % 2);
            write_reg(lsik_pkg::REG_PHASE_RATE, ph == 4 ? 0 : $urandom_range(1000, 40000));
            write_reg(lsik_pkg::REG_FOLD_THRESHOLD,
                      ph == 3 ? 25736 : $urandom_range(500, 25000));
            write_reg(3'd7, $urandom);
            if (ph == 2) hold_off = 3000;
            load_ticks(180);
            if (ph == 1) begin
                while (tick_q.size() > 90) @(posedge aclk);
                driver_pause = 1;
                while (s_tvalid || pose_q.size() > 0) @(posedge aclk);
                driver_pause = 0;
            end
            drain();
        end

        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #60ms;
        $display("FAIL");
        $finish;
    end

endmodule
